[rtl/core/tscle_pkg.sv]
package tscle_pkg;

	localparam int CMD_W  = 3;
	localparam int CH_W   = 8;
	localparam int OCNT_W = 9;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_DELETE    = 3'd1,
		CMD_BACKSPACE = 3'd2,
		CMD_LEFT      = 3'd3,
		CMD_RIGHT     = 3'd4,
		CMD_FRONT     = 3'd5,
		CMD_END       = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_PUSH_B,
		DP_POP_A,
		DP_POP_B,
		DP_MOVE_BA,
		DP_MOVE_AB
	} dp_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK_L,
		ST_WALK_R,
		ST_REPORT
	} state_t;

	typedef struct packed {
		dp_op_t          op;
		logic [CH_W-1:0] ch;
	} dp_cmd_t;

	typedef struct packed {
		logic b_empty;
		logic b_full;
		logic a_empty;
		logic a_full;
	} dp_status_t;

endpackage

[rtl/core/two_stack_cursor_line_editor_unit.sv]
// Line editor held as two character stacks of CAPACITY bytes around a cursor. One request
// (cmd in tdata[2:0], ch in tdata[10:3]) returns one status result. Insert, delete,
// backspace, left, right and unused codes go from the idle state to the report state, which
// loads the result into the output register once it is free; front and end first walk the
// cursor, moving characters one per cycle through the single write port of each stack store
// until the walk stops, and then report. Requests are taken one at a time;
// the next is taken as soon as the previous result sits in the output register, even
// while it still waits for the downstream side. Counts above 511 are reported in their
// low 9 bits. A push onto a full stack is dropped and the overflow flag is set.
module two_stack_cursor_line_editor_unit #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[2:0], ch[10:3], zero fill
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// at_front[0], at_end[1], count_before[10:2], count_after[19:11],
	// char_before[27:20], char_after[35:28], overflow[36], zero fill
	output logic [39:0] m_tdata
);
	import tscle_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > OCNT_W) ? CW : OCNT_W;

	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;
	logic [CW-1:0]     count_b, count_a;
	logic [CH_W-1:0]   top_b, top_a;
	logic              out_free, out_load, ovf;
	logic [EW-1:0]     cnt_b_ext, cnt_a_ext;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	tscle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_cmd   (s_tdata[CMD_W-1:0]),
		.req_ch    (s_tdata[CMD_W+CH_W-1:CMD_W]),
		.out_free  (out_free),
		.out_load  (out_load),
		.ovf       (ovf),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	tscle_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.count_b   (count_b),
		.count_a   (count_a),
		.top_b     (top_b),
		.top_a     (top_a)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign cnt_b_ext = EW'(count_b);
	assign cnt_a_ext = EW'(count_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {
				3'b000,
				ovf,
				dp_status.a_empty ? 8'h00 : top_a,
				dp_status.b_empty ? 8'h00 : top_b,
				cnt_a_ext[OCNT_W-1:0],
				cnt_b_ext[OCNT_W-1:0],
				dp_status.a_empty,
				dp_status.b_empty
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/tscle_datapath.sv]
module tscle_datapath #(
	parameter int CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tscle_pkg::dp_cmd_t      dp_cmd,
	output tscle_pkg::dp_status_t   dp_status,
	output logic [$clog2(CAPACITY+1)-1:0] count_b,
	output logic [$clog2(CAPACITY+1)-1:0] count_a,
	output logic [tscle_pkg::CH_W-1:0]    top_b,
	output logic [tscle_pkg::CH_W-1:0]    top_a
);
	import tscle_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [CH_W-1:0] mem_b [CAPACITY];
	logic [CH_W-1:0] mem_a [CAPACITY];

	logic [CW-1:0]   count_b_q, count_a_q;
	logic [CW-1:0]   count_b_d, count_a_d;
	logic [CH_W-1:0] top_b_q, top_a_q;
	logic            we_b, we_a;
	logic [CH_W-1:0] wd_b, wd_a;
	logic [AW-1:0]   waddr_b, waddr_a;
	logic [AW-1:0]   raddr_b, raddr_a;

	always_comb begin
		count_b_d = count_b_q;
		count_a_d = count_a_q;
		we_b      = 1'b0;
		we_a      = 1'b0;
		wd_b      = dp_cmd.ch;
		wd_a      = top_b_q;
		unique case (dp_cmd.op)
			DP_PUSH_B: begin
				we_b      = 1'b1;
				count_b_d = count_b_q + CW'(1);
			end
			DP_POP_A: begin
				count_a_d = count_a_q - CW'(1);
			end
			DP_POP_B: begin
				count_b_d = count_b_q - CW'(1);
			end
			DP_MOVE_BA: begin
				we_a      = 1'b1;
				count_a_d = count_a_q + CW'(1);
				count_b_d = count_b_q - CW'(1);
			end
			DP_MOVE_AB: begin
				we_b      = 1'b1;
				wd_b      = top_a_q;
				count_b_d = count_b_q + CW'(1);
				count_a_d = count_a_q - CW'(1);
			end
			default: begin
			end
		endcase
	end

	assign waddr_b = count_b_q[AW-1:0];
	assign waddr_a = count_a_q[AW-1:0];
	assign raddr_b = AW'(count_b_d - CW'(1));
	assign raddr_a = AW'(count_a_d - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_b_q <= '0;
			count_a_q <= '0;
		end else begin
			count_b_q <= count_b_d;
			count_a_q <= count_a_d;
		end
	end

	// keep each top register equal to the entry just below its count
	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr_b] <= wd_b;
		end
		if (we_b && (waddr_b == raddr_b)) begin
			top_b_q <= wd_b;
		end else begin
			top_b_q <= mem_b[raddr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr_a] <= wd_a;
		end
		if (we_a && (waddr_a == raddr_a)) begin
			top_a_q <= wd_a;
		end else begin
			top_a_q <= mem_a[raddr_a];
		end
	end

	assign dp_status.b_empty = (count_b_q == '0);
	assign dp_status.a_empty = (count_a_q == '0);
	assign dp_status.b_full  = (count_b_q == CW'(CAPACITY));
	assign dp_status.a_full  = (count_a_q == CW'(CAPACITY));

	assign count_b = count_b_q;
	assign count_a = count_a_q;
	assign top_b   = top_b_q;
	assign top_a   = top_a_q;

endmodule

[rtl/core/tscle_ctrl.sv]
module tscle_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [tscle_pkg::CMD_W-1:0]  req_cmd,
	input  logic [tscle_pkg::CH_W-1:0]   req_ch,
	input  logic                         out_free,
	output logic                         out_load,
	output logic                         ovf,
	input  tscle_pkg::dp_status_t        dp_status,
	output tscle_pkg::dp_cmd_t           dp_cmd
);
	import tscle_pkg::*;

	state_t state_q, state_d;
	logic   ovf_q, ovf_d;
	logic   accept;
	cmd_t   cmd;

	assign cmd    = cmd_t'(req_cmd);
	assign accept = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_FRONT: state_d = ST_WALK_L;
						CMD_END:   state_d = ST_WALK_R;
						default:   state_d = ST_REPORT;
					endcase
				end
			end
			ST_WALK_L: begin
				if (dp_status.b_empty || dp_status.a_full) begin
					state_d = ST_REPORT;
				end
			end
			ST_WALK_R: begin
				if (dp_status.a_empty || dp_status.b_full) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		out_load   = 1'b0;
		ovf_d      = ovf_q;
		dp_cmd.op  = DP_NONE;
		dp_cmd.ch  = req_ch;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (accept) begin
					ovf_d = 1'b0;
					unique case (cmd)
						CMD_INSERT: begin
							if (dp_status.b_full) begin
								ovf_d = 1'b1;
							end else begin
								dp_cmd.op = DP_PUSH_B;
							end
						end
						CMD_DELETE: begin
							if (!dp_status.a_empty) begin
								dp_cmd.op = DP_POP_A;
							end
						end
						CMD_BACKSPACE: begin
							if (!dp_status.b_empty) begin
								dp_cmd.op = DP_POP_B;
							end
						end
						CMD_LEFT: begin
							if (!dp_status.b_empty) begin
								if (dp_status.a_full) begin
									ovf_d = 1'b1;
								end else begin
									dp_cmd.op = DP_MOVE_BA;
								end
							end
						end
						CMD_RIGHT: begin
							if (!dp_status.a_empty) begin
								if (dp_status.b_full) begin
									ovf_d = 1'b1;
								end else begin
									dp_cmd.op = DP_MOVE_AB;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK_L: begin
				if (!dp_status.b_empty) begin
					if (dp_status.a_full) begin
						ovf_d = 1'b1;
					end else begin
						dp_cmd.op = DP_MOVE_BA;
					end
				end
			end
			ST_WALK_R: begin
				if (!dp_status.a_empty) begin
					if (dp_status.b_full) begin
						ovf_d = 1'b1;
					end else begin
						dp_cmd.op = DP_MOVE_AB;
					end
				end
			end
			ST_REPORT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ovf_q   <= ovf_d;
		end
	end

	assign ovf = ovf_q;

endmodule
